### design/led_gfe_pkg.sv
`default_nettype none

package led_gfe_pkg;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [7:0] BRIGHT_MAX = 8'd255;

  // one LED entry: color is blue 23:16, red 15:8, green 7:0
  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  bright;
    logic [2:0]  step;
    logic        falling;
  } entry_t;

endpackage

`default_nettype wire

### design/led_glow_fade_engine_core.sv
`default_nettype none

// channel   | dir | ports                                             | handshake
// ----------+-----+---------------------------------------------------+-------------------------
// command   | in  | action led_index new_color load_brightness        | start && !busy
//           |     | load_step load_falling                            |
// pixel     | out | pixel_index pixel_word                            | done, one cycle, no stall
//
// One word is taken every clock while busy is low; a step word gives its pixel on done after
// entry read and update, multiply, and divide by 255 in the output register.
// The per-LED entry store is a single memory, read at acceptance and written in the next cycle;
// a one-deep bypass covers back-to-back words to the same LED. busy is high only during rst;
// the store is not cleared, so the user, not the block, must load an LED before stepping it.
// Words whose led_index is not below LED_COUNT are dropped. The pixel side never stalls.

module led_glow_fade_engine_core #(
  parameter int LED_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [7:0]  led_index,
  input  wire logic [23:0] new_color,
  input  wire logic [7:0]  load_brightness,
  input  wire logic [2:0]  load_step,
  input  wire logic        load_falling,
  output logic             done,
  output logic [7:0]       pixel_index,
  output logic [23:0]      pixel_word
);

  localparam int AW     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int AW_EXT = (AW > 8) ? AW : 8;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'd1;
    t = t + 16'(t[15:8]);
    return t[15:8];
  endfunction

  led_gfe_pkg::entry_t mem [LED_COUNT];

  logic              accept;
  logic [AW_EXT-1:0] idx_ext;
  logic [AW-1:0]     rd_addr;
  logic              in_range;

  assign busy     = rst;
  assign accept   = start && !busy;
  assign idx_ext  = AW_EXT'(led_index);
  assign rd_addr  = idx_ext[AW-1:0];
  assign in_range = (32'(led_index) < LED_COUNT);

  // stage 1: registered command and memory read
  logic                s1_valid;
  logic                s1_action;
  logic [7:0]          s1_index;
  logic [AW-1:0]       s1_addr;
  logic [23:0]         s1_new_color;
  logic [7:0]          s1_load_bright;
  logic [2:0]          s1_load_step;
  logic                s1_load_falling;
  led_gfe_pkg::entry_t rd_data;

  // last write, for the word that read the memory on the same edge
  logic                wb_valid;
  logic [AW-1:0]       wb_addr;
  led_gfe_pkg::entry_t wb_data;

  led_gfe_pkg::entry_t cur;
  led_gfe_pkg::entry_t wr_data;
  logic                wr_en;
  logic [23:0]         step_color;
  logic [7:0]          bright_next;
  logic                falling_next;
  logic                is_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    s1_action       <= action;
    s1_index        <= led_index;
    s1_addr         <= rd_addr;
    s1_new_color    <= new_color;
    s1_load_bright  <= load_brightness;
    s1_load_step    <= load_step;
    s1_load_falling <= load_falling;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= s1_addr;
    wb_data <= wr_data;
  end

  assign wr_en   = s1_valid;
  assign is_step = (s1_action == led_gfe_pkg::ACT_STEP);

  always_comb begin
    cur = (wb_valid && (wb_addr == s1_addr)) ? wb_data : rd_data;
    step_color = (cur.bright == 8'd0) ? s1_new_color : cur.color;
    if (cur.falling) begin
      if (cur.bright > 8'(cur.step)) begin
        bright_next  = cur.bright - 8'(cur.step);
        falling_next = 1'b1;
      end else begin
        bright_next  = 8'd0;
        falling_next = 1'b0;
      end
    end else begin
      if (cur.bright < (led_gfe_pkg::BRIGHT_MAX - 8'(cur.step))) begin
        bright_next  = cur.bright + 8'(cur.step);
        falling_next = 1'b0;
      end else begin
        bright_next  = led_gfe_pkg::BRIGHT_MAX;
        falling_next = 1'b1;
      end
    end
    if (is_step) begin
      wr_data.color   = step_color;
      wr_data.bright  = bright_next;
      wr_data.step    = cur.step;
      wr_data.falling = falling_next;
    end else begin
      wr_data.color   = s1_new_color;
      wr_data.bright  = s1_load_bright;
      wr_data.step    = s1_load_step;
      wr_data.falling = s1_load_falling;
    end
  end

  // stage 2: color and level for scaling
  logic        s2_valid;
  logic [7:0]  s2_index;
  logic [23:0] s2_color;
  logic [7:0]  s2_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && is_step;
    end
  end

  always_ff @(posedge clk) begin
    s2_index <= s1_index;
    s2_color <= step_color;
    s2_level <= cur.bright;
  end

  // stage 3: channel products
  logic        s3_valid;
  logic [7:0]  s3_index;
  logic [15:0] s3_blue;
  logic [15:0] s3_red;
  logic [15:0] s3_green;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_index <= s2_index;
    s3_blue  <= 16'(s2_color[23:16]) * 16'(s2_level);
    s3_red   <= 16'(s2_color[15:8]) * 16'(s2_level);
    s3_green <= 16'(s2_color[7:0]) * 16'(s2_level);
  end

  // output register: divide by 255 through the reciprocal correction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_index <= s3_index;
    pixel_word  <= {div255(s3_blue), div255(s3_red), div255(s3_green)};
  end

  a_done_from_step: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && in_range && (action == led_gfe_pkg::ACT_STEP), 4))
    else $error("pixel without an accepted step word");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !is_step) |=> !s2_valid)
    else $error("load word entered the scaling pipe");

  a_index_carried: assert property (@(posedge clk) disable iff (rst)
    s3_valid |=> (done && (pixel_index == $past(s3_index))))
    else $error("pixel lost or index changed at output");

  a_clamp_low: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && is_step && cur.falling && (bright_next == 8'd0)) |-> !falling_next)
    else $error("fade out reached zero without turning");

  a_clamp_high: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && is_step && !cur.falling && (bright_next == led_gfe_pkg::BRIGHT_MAX))
      |-> falling_next)
    else $error("fade in reached full without turning");

endmodule

`default_nettype wire
